@@ rtl/core/tlfk_pkg.sv @@
// Shared constants, types and table functions for the two-link arm kinematics unit.
package tlfk_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int TABLE_BITS  = 12;

  localparam int TBL_SIZE  = 1 << TABLE_BITS;
  localparam int QUARTER   = TBL_SIZE / 4;
  localparam int ADDR_W    = TABLE_BITS - 1;
  localparam int IDX_W     = (ANGLE_WIDTH > TABLE_BITS) ? ANGLE_WIDTH : TABLE_BITS;
  localparam int IDX_SHR   = (ANGLE_WIDTH >= TABLE_BITS) ? (ANGLE_WIDTH - TABLE_BITS) : 0;
  localparam int IDX_SHL   = (ANGLE_WIDTH >= TABLE_BITS) ? 0 : (TABLE_BITS - ANGLE_WIDTH);

  localparam int LEN_W     = 16;
  localparam int DELTA_W   = 16;
  localparam int SINE_W    = 15;
  localparam int ELBOW_W   = 17;
  localparam int TIP_W     = 18;
  localparam int ANG_OUT_W = 16;
  localparam int PROD_W    = LEN_W + 1 + SINE_W + 1;
  localparam int SCALED_W  = PROD_W - 15;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEN = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = 16'd256;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] PI_STEP = PI_Q62 / (TBL_SIZE / 2);

  typedef logic [SINE_W-1:0] qsin_tab_t [0:QUARTER];

  // Quarter-table address and sign of one sine lookup
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              neg;
  } lookup_t;

  // Sine and cosine magnitudes with their signs for one angle
  typedef struct packed {
    logic [SINE_W-1:0] sin_mag;
    logic [SINE_W-1:0] cos_mag;
    logic              sin_neg;
    logic              cos_neg;
  } trig_t;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(32767 * sin(2*pi*i/TBL_SIZE)) for the first quarter turn, Taylor series in Q62
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    logic        sub;
    for (int i = 0; i <= QUARTER; i++) begin
      x    = PI_STEP * 64'(i);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      sub  = 1'b1;
      for (int k = 3; k < 80; k += 2) begin
        if (term != 64'd0) begin
          term = mul_q62(term, x2) / 64'(k * (k - 1));
          if (sub) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
          sub = !sub;
        end
      end
      rnd    = (((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
      tab[i] = rnd[SINE_W-1:0];
    end
    return tab;
  endfunction

  function automatic logic [TABLE_BITS-1:0] angle_index(logic [ANGLE_WIDTH-1:0] angle);
    logic [IDX_W-1:0] wide;
    wide = (IDX_W'(angle) >> IDX_SHR) << IDX_SHL;
    return wide[TABLE_BITS-1:0];
  endfunction

  // Fold a full-turn index onto the quarter table
  function automatic lookup_t sine_lookup(logic [TABLE_BITS-1:0] idx);
    lookup_t           r;
    logic [ADDR_W-1:0] low;
    low = {1'b0, idx[TABLE_BITS-3:0]};
    if (idx[TABLE_BITS-2]) begin
      r.addr = ADDR_W'(QUARTER) - low;
    end else begin
      r.addr = low;
    end
    r.neg = idx[TABLE_BITS-1];
    return r;
  endfunction

endpackage

@@ rtl/core/two_link_arm_forward_kinematics_unit.sv @@
// Top level of the two-link planar arm forward kinematics unit.
// A taken word moves through stage 1, table read, multiply and output register in turn.
// One word per cycle unless stalled; four stages (angle, table read, multiply, sum).
// The four stages advance on their own, so bubbles close up while the output is stalled.
// Reset (rst, synchronous, active high) zeroes both joint angles, sets both link
// lengths to 1.0 (256 in Q8.8) and empties the pipeline.
module two_link_arm_forward_kinematics_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [tlfk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tlfk_pkg::LEN_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tlfk_pkg::DELTA_W-1:0]    delta_shoulder,
  input  logic signed [tlfk_pkg::DELTA_W-1:0]    delta_elbow,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tlfk_pkg::ELBOW_W-1:0]    elbow_x,
  output logic signed [tlfk_pkg::ELBOW_W-1:0]    elbow_y,
  output logic signed [tlfk_pkg::TIP_W-1:0]      tip_x,
  output logic signed [tlfk_pkg::TIP_W-1:0]      tip_y,
  output logic [tlfk_pkg::ANG_OUT_W-1:0]         shoulder_angle,
  output logic [tlfk_pkg::ANG_OUT_W-1:0]         elbow_angle
);
  import tlfk_pkg::*;

  // Configuration: link lengths, to be written only while idle; the block does not enforce this
  logic [LEN_W-1:0] upper_len;
  logic [LEN_W-1:0] lower_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= LEN_RESET;
      lower_len <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPPER_LEN: upper_len <= cfg_data;
        CFG_LOWER_LEN: lower_len <= cfg_data;
        default:       upper_len <= upper_len;
      endcase
    end
  end

  // Stage valid bits and per-stage advance; a stage moves when the next one is
  // empty or moving itself
  logic v1, v2, v3;
  logic en1, en2, en3, en_o;
  logic accept;

  assign en_o     = !out_valid || !out_stall;
  assign en3      = !v3 || en_o;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en_o) out_valid <= v3;
    end
  end

  // Joint angle accumulators, wrapping modulo one turn
  logic [ANGLE_WIDTH-1:0] shoulder_acc, shoulder_acc_next;
  logic [ANGLE_WIDTH-1:0] elbow_acc, elbow_acc_next;

  assign shoulder_acc_next = shoulder_acc + ANGLE_WIDTH'(delta_shoulder);
  assign elbow_acc_next    = elbow_acc + ANGLE_WIDTH'(delta_elbow);

  always_ff @(posedge clk) begin
    if (rst) begin
      shoulder_acc <= '0;
      elbow_acc    <= '0;
    end else if (accept) begin
      shoulder_acc <= shoulder_acc_next;
      elbow_acc    <= elbow_acc_next;
    end
  end

  // Stage 1: hold the updated angles of the word
  logic [ANGLE_WIDTH-1:0] ang1_s1, ang2_s1;

  always_ff @(posedge clk) begin
    if (accept) begin
      ang1_s1 <= shoulder_acc_next;
      ang2_s1 <= elbow_acc_next;
    end
  end

  // Fold the shoulder angle and the summed angle onto the quarter table; cosine
  // is the sine a quarter turn ahead
  logic [ANGLE_WIDTH-1:0] ang12_s1;
  logic [TABLE_BITS-1:0]  idx1, idx12;
  lookup_t                lk1_sin, lk1_cos, lk12_sin, lk12_cos;

  assign ang12_s1 = ang1_s1 + ang2_s1;
  assign idx1     = angle_index(ang1_s1);
  assign idx12    = angle_index(ang12_s1);
  assign lk1_sin  = sine_lookup(idx1);
  assign lk1_cos  = sine_lookup(idx1 + TABLE_BITS'(QUARTER));
  assign lk12_sin = sine_lookup(idx12);
  assign lk12_cos = sine_lookup(idx12 + TABLE_BITS'(QUARTER));

  // Stage 2: table read, signs and angles ride along
  trig_t                  trig1, trig12;
  logic [SINE_W-1:0]      sin1_mag, cos1_mag, sin12_mag, cos12_mag;
  logic                   sin1_neg, cos1_neg, sin12_neg, cos12_neg;
  logic [ANGLE_WIDTH-1:0] ang1_s2, ang2_s2;

  tlfk_sine_rom u_rom_shoulder (
    .clk    (clk),
    .en     (en2),
    .addr_a (lk1_sin.addr),
    .addr_b (lk1_cos.addr),
    .data_a (sin1_mag),
    .data_b (cos1_mag)
  );

  tlfk_sine_rom u_rom_tip (
    .clk    (clk),
    .en     (en2),
    .addr_a (lk12_sin.addr),
    .addr_b (lk12_cos.addr),
    .data_a (sin12_mag),
    .data_b (cos12_mag)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      sin1_neg  <= lk1_sin.neg;
      cos1_neg  <= lk1_cos.neg;
      sin12_neg <= lk12_sin.neg;
      cos12_neg <= lk12_cos.neg;
      ang1_s2   <= ang1_s1;
      ang2_s2   <= ang2_s1;
    end
  end

  // Pack magnitudes and signs in trig_t field order
  assign trig1  = {sin1_mag, cos1_mag, sin1_neg, cos1_neg};
  assign trig12 = {sin12_mag, cos12_mag, sin12_neg, cos12_neg};

  // Stage 3: four products, one link per unit
  logic signed [SCALED_W-1:0] p1x, p1y, p2x, p2y;
  logic [ANGLE_WIDTH-1:0]     ang1_s3, ang2_s3;

  tlfk_link_mult u_mult_upper (
    .clk  (clk),
    .en   (en3),
    .len  (upper_len),
    .trig (trig1),
    .x    (p1x),
    .y    (p1y)
  );

  tlfk_link_mult u_mult_lower (
    .clk  (clk),
    .en   (en3),
    .len  (lower_len),
    .trig (trig12),
    .x    (p2x),
    .y    (p2y)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      ang1_s3 <= ang1_s2;
      ang2_s3 <= ang2_s2;
    end
  end

  // Output register: elbow is the first link, tip adds the second; hold while stalled
  logic signed [TIP_W-1:0] tip_x_next, tip_y_next;

  assign tip_x_next = TIP_W'(p1x) + TIP_W'(p2x);
  assign tip_y_next = TIP_W'(p1y) + TIP_W'(p2y);

  always_ff @(posedge clk) begin
    if (en_o) begin
      elbow_x        <= p1x[ELBOW_W-1:0];
      elbow_y        <= p1y[ELBOW_W-1:0];
      tip_x          <= tip_x_next;
      tip_y          <= tip_y_next;
      shoulder_angle <= ANG_OUT_W'(ang1_s3);
      elbow_angle    <= ANG_OUT_W'(ang2_s3);
    end
  end

  // An accepted word always lands in stage 1
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted word did not enter stage 1");

  // Accumulators advance by exactly the accepted increments
  a_acc_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (shoulder_acc == $past(shoulder_acc_next)) &&
               (elbow_acc == $past(elbow_acc_next)))
    else $error("joint angle accumulator mismatch");

  // Accumulators move only on an accepted word
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(shoulder_acc) && $stable(elbow_acc))
    else $error("joint angle changed without an accepted word");

  // A blocked stage 3 keeps its word
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !en3) |=> v3)
    else $error("stage 3 word dropped while blocked");

  // A full pipeline behind a stalled output refuses input
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && v1 && v2 && v3) |-> in_stall)
    else $error("input taken while pipeline full and output stalled");

endmodule

@@ rtl/core/tlfk_sine_rom.sv @@
// Quarter-wave sine table with two registered read ports.
module tlfk_sine_rom (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tlfk_pkg::ADDR_W-1:0]    addr_a,
  input  logic [tlfk_pkg::ADDR_W-1:0]    addr_b,
  output logic [tlfk_pkg::SINE_W-1:0]    data_a,
  output logic [tlfk_pkg::SINE_W-1:0]    data_b
);
  import tlfk_pkg::*;

  localparam qsin_tab_t QSIN = build_qsin();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= QSIN[addr_a];
      data_b <= QSIN[addr_b];
    end
  end

endmodule

@@ rtl/core/tlfk_link_mult.sv @@
// One link: length times cosine and sine, floor-shifted by 15, registered.
module tlfk_link_mult (
  input  logic                            clk,
  input  logic                            en,
  input  logic [tlfk_pkg::LEN_W-1:0]      len,
  input  tlfk_pkg::trig_t                 trig,
  output logic signed [tlfk_pkg::SCALED_W-1:0] x,
  output logic signed [tlfk_pkg::SCALED_W-1:0] y
);
  import tlfk_pkg::*;

  logic signed [SINE_W:0]   cos_val;
  logic signed [SINE_W:0]   sin_val;
  logic signed [LEN_W:0]    len_s;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;

  assign len_s   = signed'({1'b0, len});
  assign cos_val = trig.cos_neg ? -signed'({1'b0, trig.cos_mag}) : signed'({1'b0, trig.cos_mag});
  assign sin_val = trig.sin_neg ? -signed'({1'b0, trig.sin_mag}) : signed'({1'b0, trig.sin_mag});
  assign prod_x  = len_s * cos_val;
  assign prod_y  = len_s * sin_val;

  // arithmetic shift gives floor division by 2^15
  always_ff @(posedge clk) begin
    if (en) begin
      x <= prod_x[PROD_W-1:15];
      y <= prod_y[PROD_W-1:15];
    end
  end

endmodule

@@ tb/sv/two_link_arm_forward_kinematics_unit_tb.sv @@
// Self-checking testbench for the two-link planar arm forward kinematics unit.
module two_link_arm_forward_kinematics_unit_tb;

  import tlfk_pkg::*;

  // Hold the output stalled this long in the back-pressure test
  localparam int HOLD_CYCLES    = 300;
  // End the run after this many cycles with no word moving on either side
  localparam int WATCHDOG_LIMIT = 4000;
  // Idle cycles after the last pose word has come back
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam real MATH_PI       = 3.14159265358979323846;

  // One pose word as the block presents it
  typedef struct {
    logic signed [ELBOW_W-1:0]   ex;
    logic signed [ELBOW_W-1:0]   ey;
    logic signed [TIP_W-1:0]     tx;
    logic signed [TIP_W-1:0]     ty;
    logic [ANG_OUT_W-1:0]        shoulder;
    logic [ANG_OUT_W-1:0]        elbow;
  } arm_pose_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [LEN_W-1:0]            cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [DELTA_W-1:0]   delta_shoulder;
  logic signed [DELTA_W-1:0]   delta_elbow;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [ELBOW_W-1:0]   elbow_x;
  logic signed [ELBOW_W-1:0]   elbow_y;
  logic signed [TIP_W-1:0]     tip_x;
  logic signed [TIP_W-1:0]     tip_y;
  logic [ANG_OUT_W-1:0]        shoulder_angle;
  logic [ANG_OUT_W-1:0]        elbow_angle;

  // Mirror of the block's joint angles and link lengths
  logic [ANGLE_WIDTH-1:0]      shoulder_turn;
  logic [ANGLE_WIDTH-1:0]      elbow_turn;
  logic [LEN_W-1:0]            upper_len;
  logic [LEN_W-1:0]            lower_len;

  // First quarter of the sine wave, scaled to 32767
  int                          quarter_wave [0:QUARTER];

  arm_pose_t                   expected_poses [$];

  int                          tx_idle_pct;
  int                          rx_stall_pct;
  int unsigned                 hold_seq;
  int unsigned                 hold_seen;
  int unsigned                 hold_left;
  int unsigned                 quiet_cycles;
  int unsigned                 mismatches;
  int unsigned                 commands_sent;
  int unsigned                 poses_checked;
  int unsigned                 length_settings;

  two_link_arm_forward_kinematics_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .delta_shoulder (delta_shoulder),
    .delta_elbow    (delta_elbow),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .elbow_x        (elbow_x),
    .elbow_y        (elbow_y),
    .tip_x          (tip_x),
    .tip_y          (tip_y),
    .shoulder_angle (shoulder_angle),
    .elbow_angle    (elbow_angle)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pose prediction
  // ---------------------------------------------------------------------------

  // Fill the quarter wave; the other three quarters follow by symmetry
  function automatic void build_quarter_wave();
    real phase;
    for (int i = 0; i <= QUARTER; i++) begin
      phase = 2.0 * MATH_PI * real'(i) / real'(TBL_SIZE);
      quarter_wave[i] = $rtoi(32767.0 * $sin(phase) + 0.5);
    end
  endfunction

  // Sine of a full-turn table index, folded onto the quarter wave
  function automatic int sine_of(logic [TABLE_BITS-1:0] idx);
    int off;
    off = int'(idx[TABLE_BITS-3:0]);
    case (idx[TABLE_BITS-1:TABLE_BITS-2])
      2'd0: begin
        return quarter_wave[off];
      end
      2'd1: begin
        return quarter_wave[QUARTER - off];
      end
      2'd2: begin
        return -quarter_wave[off];
      end
      default: begin
        return -quarter_wave[QUARTER - off];
      end
    endcase
  endfunction

  // Link length times a table value, floored back to Q8.8
  function automatic longint scale_link(longint len, int s);
    longint p;
    p = len * s;
    return p >>> 15;
  endfunction

  // Advance both joints by one command and work out the resulting pose
  function automatic arm_pose_t advance_arm(logic signed [DELTA_W-1:0] ds,
                                            logic signed [DELTA_W-1:0] de);
    arm_pose_t              pose;
    logic [ANGLE_WIDTH-1:0] reach;
    logic [TABLE_BITS-1:0]  i1;
    logic [TABLE_BITS-1:0]  i12;
    longint                 ex;
    longint                 ey;
    longint                 tx;
    longint                 ty;
    shoulder_turn = shoulder_turn + ANGLE_WIDTH'(ds);
    elbow_turn    = elbow_turn + ANGLE_WIDTH'(de);
    reach         = shoulder_turn + elbow_turn;
    i1            = shoulder_turn[ANGLE_WIDTH-1 -: TABLE_BITS];
    i12           = reach[ANGLE_WIDTH-1 -: TABLE_BITS];
    ex = scale_link(longint'(upper_len), sine_of(i1 + TABLE_BITS'(QUARTER)));
    ey = scale_link(longint'(upper_len), sine_of(i1));
    tx = ex + scale_link(longint'(lower_len), sine_of(i12 + TABLE_BITS'(QUARTER)));
    ty = ey + scale_link(longint'(lower_len), sine_of(i12));
    pose.ex       = ELBOW_W'(ex);
    pose.ey       = ELBOW_W'(ey);
    pose.tx       = TIP_W'(tx);
    pose.ty       = TIP_W'(ty);
    pose.shoulder = shoulder_turn;
    pose.elbow    = elbow_turn;
    return pose;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every task starts and ends in the step of a rising edge
  // ---------------------------------------------------------------------------

  // Mostly full-range deltas, plus fine sweeps, quarter turns and table-step nudges
  function automatic logic signed [DELTA_W-1:0] pick_delta();
    int unsigned kind;
    int          step;
    kind = $urandom_range(99);
    if (kind < 50) begin
      return DELTA_W'($urandom);
    end else if (kind < 75) begin
      return DELTA_W'(int'($urandom_range(128)) - 64);
    end else if (kind < 90) begin
      return DELTA_W'($urandom_range(3) * 16384);
    end
    step = $urandom_range(1) ? 16 : 1;
    if ($urandom_range(1)) begin
      step = -step;
    end
    return DELTA_W'(step);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      return '0;
    end else if (kind == 1) begin
      return '1;
    end
    return LEN_W'($urandom_range(65535));
  endfunction

  // Offer one command word, hold it through stalls, and log its pose once taken
  task automatic send_word(input logic signed [DELTA_W-1:0] ds,
                           input logic signed [DELTA_W-1:0] de);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    delta_shoulder <= ds;
    delta_elbow    <= de;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_poses.push_back(advance_arm(ds, de));
    commands_sent++;
  endtask

  // Drop valid, wait for every pose to come back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both link lengths on back-to-back edges; call only when idle
  task automatic set_lengths(input logic [LEN_W-1:0] upper, input logic [LEN_W-1:0] lower);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UPPER_LEN;
    cfg_data  <= upper;
    @(posedge clk);
    upper_len = upper;
    cfg_index <= CFG_LOWER_LEN;
    cfg_data  <= lower;
    @(posedge clk);
    lower_len = lower;
    cfg_we    <= 1'b0;
    length_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, table-step edges, quarter turns and wrap, at reset lengths
  task automatic test_directed_angles();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_word(16'sd0, 16'sd0);
    send_word(16'sd32767, 16'sd0);
    send_word(-16'sd32768, 16'sd0);
    send_word(16'sd0, 16'sd32767);
    send_word(16'sd0, -16'sd32768);
    send_word(16'sd1, 16'sd1);
    send_word(-16'sd1, -16'sd1);
    send_word(16'sd15, 16'sd15);
    send_word(16'sd1, 16'sd1);
    send_word(16'sd16384, 16'sd0);
    send_word(16'sd16384, 16'sd16384);
    send_word(16'sd16384, 16'sd16384);
    send_word(16'sd16384, 16'sd16384);
    send_word(16'sd32767, 16'sd32767);
    send_word(-16'sd32768, -16'sd32768);
    send_word(16'sh5555, -16'sh5556);
    send_word(-16'sh5556, 16'sh5555);
    send_word(-16'sd16, 16'sd16);
    drain();
  endtask

  // Zero and full-scale links in every pairing
  task automatic test_link_extremes();
    for (int c = 0; c < 4; c++) begin
      set_lengths((c & 1) ? 16'hFFFF : 16'h0000, (c & 2) ? 16'hFFFF : 16'h0000);
      repeat (8) send_word(pick_delta(), pick_delta());
      drain();
    end
  endtask

  // Random commands at random lengths under one idle/stall mix
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    set_lengths(pick_length(), pick_length());
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_word(pick_delta(), pick_delta());
    drain();
  endtask

  // Hold the output off for a long stretch while commands keep coming
  task automatic test_output_holdoff();
    set_lengths(pick_length(), pick_length());
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_seq++;
    repeat (100) send_word(pick_delta(), pick_delta());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each taken pose word with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    arm_pose_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: pose word with no command pending", $time);
        end
      end else begin
        want = expected_poses.pop_front();
        poses_checked++;
        if (elbow_x !== want.ex || elbow_y !== want.ey || tip_x !== want.tx ||
            tip_y !== want.ty || shoulder_angle !== want.shoulder ||
            elbow_angle !== want.elbow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: pose mismatch, expected elbow (%0d,%0d) tip (%0d,%0d) angles %h %h",
                     $time, want.ex, want.ey, want.tx, want.ty, want.shoulder, want.elbow);
            $display("%0t:                got      elbow (%0d,%0d) tip (%0d,%0d) angles %h %h",
                     $time, elbow_x, elbow_y, tip_x, tip_y, shoulder_angle, elbow_angle);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d poses outstanding",
               quiet_cycles, expected_poses.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_UPPER_LEN;
    cfg_data        = '0;
    in_valid        = 1'b0;
    delta_shoulder  = '0;
    delta_elbow     = '0;
    out_stall       = 1'b0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_seq        = 0;
    hold_seen       = 0;
    hold_left       = 0;
    quiet_cycles    = 0;
    mismatches      = 0;
    commands_sent   = 0;
    poses_checked   = 0;
    length_settings = 1;
    shoulder_turn   = '0;
    elbow_turn      = '0;
    upper_len       = LEN_RESET;
    lower_len       = LEN_RESET;
    build_quarter_wave();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_angles();
    test_link_extremes();
    test_random_traffic(0, 0, 280);
    test_random_traffic(78, 0, 280);
    test_random_traffic(0, 78, 280);
    test_random_traffic(27, 27, 280);
    test_output_holdoff();

    $display("Ran %0d joint commands over %0d link-length settings, zero and full scale included.",
             commands_sent, length_settings);
    $display("Checked %0d pose words under four idle/stall mixes and a %0d-cycle output hold-off.",
             poses_checked, HOLD_CYCLES);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d poses never returned", mismatches, expected_poses.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tlfk_pkg.sv
rtl/core/tlfk_sine_rom.sv
rtl/core/tlfk_link_mult.sv
rtl/core/two_link_arm_forward_kinematics_unit.sv
tb/sv/two_link_arm_forward_kinematics_unit_tb.sv
